// ===== rtl/srect_pkg.sv =====
// Shared types, widths and sign helpers for the segment/rectangle hit pipeline.
// No dependencies; every rtl module imports this package.
package srect_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
    localparam int CROSS_WIDTH = PROD_WIDTH + 1;
    localparam int NUM_STAGES  = 4;
    localparam int CNT_WIDTH   = $clog2(NUM_STAGES + 1);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [CROSS_WIDTH-1:0] cross_t;

    // Sign as two flags; both low means zero
    typedef struct packed {
        logic pos;
        logic neg;
    } sign_t;

    // Raw request fields
    typedef struct packed {
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
    } in_t;

    // After stage 1: differences, extents, edge-line side tests
    typedef struct packed {
        diff_t      dx;
        diff_t      dy;
        diff_t      cxa;
        diff_t      cxb;
        diff_t      cya;
        diff_t      cyb;
        logic [3:0] side_ok;
        coord_t     ax;
        coord_t     ay;
        coord_t     bx;
        coord_t     by;
        coord_t     sx;
        coord_t     sy;
        coord_t     xlo;
        coord_t     xhi;
        coord_t     ylo;
        coord_t     yhi;
        coord_t     sxlo;
        coord_t     sxhi;
        coord_t     sylo;
        coord_t     syhi;
    } s1_t;

    // After stage 2: partial products, box overlap, inside flag
    typedef struct packed {
        prod_t      p_dx_cya;
        prod_t      p_dx_cyb;
        prod_t      p_dy_cxa;
        prod_t      p_dy_cxb;
        logic [3:0] side_ok;
        logic [3:0] box_ok;
        logic       start_in;
    } s2_t;

    // After stage 3: segment cross product against each corner
    typedef struct packed {
        cross_t [3:0] corner_cross;
        logic [3:0]   side_ok;
        logic [3:0]   box_ok;
        logic         start_in;
    } s3_t;

    function automatic coord_t min2(coord_t a, coord_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic coord_t max2(coord_t a, coord_t b);
        return (a > b) ? a : b;
    endfunction

    // Sign of a - b
    function automatic sign_t cmp_sign(coord_t a, coord_t b);
        sign_t s;
        s.pos = (a > b);
        s.neg = (a < b);
        return s;
    endfunction

    function automatic sign_t sign_mul(sign_t a, sign_t b);
        sign_t s;
        s.pos = (a.pos && b.pos) || (a.neg && b.neg);
        s.neg = (a.pos && b.neg) || (a.neg && b.pos);
        return s;
    endfunction

    // True when the product of the two signs is <= 0
    function automatic logic straddle(sign_t a, sign_t b);
        return !((a.pos && b.pos) || (a.neg && b.neg));
    endfunction

    function automatic sign_t cross_sign(cross_t c);
        sign_t s;
        s.neg = c[CROSS_WIDTH-1];
        s.pos = !c[CROSS_WIDTH-1] && (c != '0);
        return s;
    endfunction

endpackage

// ===== rtl/srect_prep.sv =====
// Stage 1: coordinate differences, extents and edge-line side tests.
// Depends on srect_pkg.
module srect_prep import srect_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output s1_t  out_data
);

    logic valid_reg;
    s1_t  data_reg;
    s1_t  data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Differences and extents
    always_comb
    begin
        sign_t c0;
        sign_t c1;
        sign_t c2;
        sign_t c3;
        data_next.dx  = DIFF_WIDTH'(in_data.ex) - DIFF_WIDTH'(in_data.sx);
        data_next.dy  = DIFF_WIDTH'(in_data.ey) - DIFF_WIDTH'(in_data.sy);
        data_next.cxa = DIFF_WIDTH'(in_data.ax) - DIFF_WIDTH'(in_data.sx);
        data_next.cxb = DIFF_WIDTH'(in_data.bx) - DIFF_WIDTH'(in_data.sx);
        data_next.cya = DIFF_WIDTH'(in_data.ay) - DIFF_WIDTH'(in_data.sy);
        data_next.cyb = DIFF_WIDTH'(in_data.by) - DIFF_WIDTH'(in_data.sy);
        data_next.ax   = in_data.ax;
        data_next.ay   = in_data.ay;
        data_next.bx   = in_data.bx;
        data_next.by   = in_data.by;
        data_next.sx   = in_data.sx;
        data_next.sy   = in_data.sy;
        data_next.xlo  = min2(in_data.ax, in_data.bx);
        data_next.xhi  = max2(in_data.ax, in_data.bx);
        data_next.ylo  = min2(in_data.ay, in_data.by);
        data_next.yhi  = max2(in_data.ay, in_data.by);
        data_next.sxlo = min2(in_data.sx, in_data.ex);
        data_next.sxhi = max2(in_data.sx, in_data.ex);
        data_next.sylo = min2(in_data.sy, in_data.ey);
        data_next.syhi = max2(in_data.sy, in_data.ey);

        // Edges are axis aligned, so each endpoint's orientation against an
        // edge is the edge direction sign times one coordinate compare.
        // A sign flip common to both endpoints cancels in the product.
        c0 = cmp_sign(in_data.by, in_data.ay);
        c1 = cmp_sign(in_data.bx, in_data.ax);
        c2 = cmp_sign(in_data.ay, in_data.by);
        c3 = cmp_sign(in_data.ax, in_data.bx);
        data_next.side_ok[0] = straddle(sign_mul(c0, cmp_sign(in_data.sx, in_data.ax)),
                                        sign_mul(c0, cmp_sign(in_data.ex, in_data.ax)));
        data_next.side_ok[1] = straddle(sign_mul(c1, cmp_sign(in_data.sy, in_data.by)),
                                        sign_mul(c1, cmp_sign(in_data.ey, in_data.by)));
        data_next.side_ok[2] = straddle(sign_mul(c2, cmp_sign(in_data.sx, in_data.bx)),
                                        sign_mul(c2, cmp_sign(in_data.ex, in_data.bx)));
        data_next.side_ok[3] = straddle(sign_mul(c3, cmp_sign(in_data.sy, in_data.ay)),
                                        sign_mul(c3, cmp_sign(in_data.ey, in_data.ay)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

// ===== rtl/srect_mult.sv =====
// Stage 2: the four segment-by-corner partial products, edge box overlap
// and the strict inside test. Depends on srect_pkg.
module srect_mult import srect_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  s1_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output s2_t  out_data
);

    logic valid_reg;
    s2_t  data_reg;
    s2_t  data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        coord_t elo_x [4];
        coord_t ehi_x [4];
        coord_t elo_y [4];
        coord_t ehi_y [4];
        // 17 x 17 signed products, operands sign-extended to the product width
        data_next.p_dx_cya = PROD_WIDTH'(in_data.dx) * PROD_WIDTH'(in_data.cya);
        data_next.p_dx_cyb = PROD_WIDTH'(in_data.dx) * PROD_WIDTH'(in_data.cyb);
        data_next.p_dy_cxa = PROD_WIDTH'(in_data.dy) * PROD_WIDTH'(in_data.cxa);
        data_next.p_dy_cxb = PROD_WIDTH'(in_data.dy) * PROD_WIDTH'(in_data.cxb);
        data_next.side_ok  = in_data.side_ok;

        // Edge extents: left, top, right, bottom as the corners walk round
        elo_x[0] = in_data.ax;  ehi_x[0] = in_data.ax;
        elo_y[0] = in_data.ylo; ehi_y[0] = in_data.yhi;
        elo_x[1] = in_data.xlo; ehi_x[1] = in_data.xhi;
        elo_y[1] = in_data.by;  ehi_y[1] = in_data.by;
        elo_x[2] = in_data.bx;  ehi_x[2] = in_data.bx;
        elo_y[2] = in_data.ylo; ehi_y[2] = in_data.yhi;
        elo_x[3] = in_data.xlo; ehi_x[3] = in_data.xhi;
        elo_y[3] = in_data.ay;  ehi_y[3] = in_data.ay;
        for (int k = 0; k < 4; k++)
        begin
            data_next.box_ok[k] = !(elo_x[k] > in_data.sxhi || elo_y[k] > in_data.syhi ||
                                    in_data.sxlo > ehi_x[k] || in_data.sylo > ehi_y[k]);
        end

        data_next.start_in = (in_data.xlo < in_data.sx) && (in_data.xhi > in_data.sx) &&
                             (in_data.ylo < in_data.sy) && (in_data.yhi > in_data.sy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

// ===== rtl/srect_cross.sv =====
// Stage 3: cross product of the segment direction with each corner offset.
// Depends on srect_pkg.
module srect_cross import srect_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  s2_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output s3_t  out_data
);

    logic valid_reg;
    s3_t  data_reg;
    s3_t  data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Corners in order A, (Ax,By), B, (Bx,Ay)
    always_comb
    begin
        data_next.corner_cross[0] = CROSS_WIDTH'(in_data.p_dx_cya)
                                  - CROSS_WIDTH'(in_data.p_dy_cxa);
        data_next.corner_cross[1] = CROSS_WIDTH'(in_data.p_dx_cyb)
                                  - CROSS_WIDTH'(in_data.p_dy_cxa);
        data_next.corner_cross[2] = CROSS_WIDTH'(in_data.p_dx_cyb)
                                  - CROSS_WIDTH'(in_data.p_dy_cxb);
        data_next.corner_cross[3] = CROSS_WIDTH'(in_data.p_dx_cya)
                                  - CROSS_WIDTH'(in_data.p_dy_cxb);
        data_next.side_ok  = in_data.side_ok;
        data_next.box_ok   = in_data.box_ok;
        data_next.start_in = in_data.start_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

// ===== rtl/segment_rectangle_intersect.sv =====
// Top level: segment versus axis-aligned rectangle hit test, four stages.
// Depends on srect_pkg, srect_prep, srect_mult, srect_cross.
//
//   channel   handshake             payload
//   -------   -------------------   ------------------------------------------
//   in        in_valid / in_ready   seg_start_*, seg_end_*, corner_a_*, corner_b_*
//   out       out_valid / out_ready hit
//
// One request per cycle while out_ready is high; each result is offered on out
// after its request passes through four registers (stage 1 differences, stage 2
// multipliers, stage 3 cross subtract, stage 4 sign decode and hit register).
// Each stage holds its own valid bit, so an empty stage takes a request even
// while the output waits; with out_ready low and all stages full, in_ready drops.
// Reset clears the valid bits and the in-flight count only.
module segment_rectangle_intersect import srect_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  coord_t seg_start_x,
    input  coord_t seg_start_y,
    input  coord_t seg_end_x,
    input  coord_t seg_end_y,
    input  coord_t corner_a_x,
    input  coord_t corner_a_y,
    input  coord_t corner_b_x,
    input  coord_t corner_b_y,
    output logic   out_valid,
    input  logic   out_ready,
    output logic   hit
);

    in_t  req;
    s1_t  s1_data;
    s2_t  s2_data;
    s3_t  s3_data;
    logic s1_valid;
    logic s1_ready;
    logic s2_valid;
    logic s2_ready;
    logic s3_valid;
    logic s3_ready;

    logic out_valid_reg;
    logic hit_reg;
    logic hit_next;

    logic [CNT_WIDTH-1:0] flight_cnt_reg;
    logic [CNT_WIDTH-1:0] flight_cnt_next;

    assign req.sx = seg_start_x;
    assign req.sy = seg_start_y;
    assign req.ex = seg_end_x;
    assign req.ey = seg_end_y;
    assign req.ax = corner_a_x;
    assign req.ay = corner_a_y;
    assign req.bx = corner_b_x;
    assign req.by = corner_b_y;

    srect_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (req),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    srect_mult u_mult
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    srect_cross u_cross
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .out_data  (s3_data)
    );

    // Stage 4: edge k spans corners k and k+1
    always_comb
    begin
        sign_t o [4];
        hit_next = s3_data.start_in;
        for (int k = 0; k < 4; k++)
        begin
            o[k] = cross_sign(s3_data.corner_cross[k]);
        end
        for (int k = 0; k < 4; k++)
        begin
            if (s3_data.box_ok[k] && s3_data.side_ok[k] && straddle(o[k], o[(k + 1) % 4]))
                hit_next = 1'b1;
        end
    end

    assign s3_ready  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s3_ready)
            out_valid_reg <= s3_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid && s3_ready)
            hit_reg <= hit_next;
    end

    // Requests in flight, for checking the valid bits
    always_comb
    begin
        flight_cnt_next = flight_cnt_reg;
        if (in_valid && in_ready)
            flight_cnt_next = flight_cnt_next + CNT_WIDTH'(1);
        if (out_valid && out_ready)
            flight_cnt_next = flight_cnt_next - CNT_WIDTH'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flight_cnt_reg <= '0;
        else
            flight_cnt_reg <= flight_cnt_next;
    end

    // Every request in flight sits in exactly one stage
    a_flight_matches_valids: assert property (@(posedge clk) disable iff (!rst_n)
        flight_cnt_reg == CNT_WIDTH'($countones({s1_valid, s2_valid, s3_valid, out_valid})))
        else $error("in-flight count does not match stage valid bits");

    // No backpressure downstream means the pipe never stalls the input
    a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output is ready");

    // A finished stage 3 item moves to the output when it is free
    a_stage3_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid && out_ready) |=> out_valid)
        else $error("stage 3 item lost on its way to the output");

    // An accepted request lands in stage 1
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s1_valid)
        else $error("accepted request not captured by stage 1");

endmodule
